// ----- hdl/samc_pkg.sv -----
`default_nettype none

package samc_pkg;

	// Request codes carried in the req_type field of an input word.
	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_DETECT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WIDTH_A  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT_A = 2'd1;
	localparam logic [1:0] CFG_WIDTH_B  = 2'd2;
	localparam logic [1:0] CFG_HEIGHT_B = 2'd3;

	localparam logic [6:0] SIZE_RESET = 7'd64;

	// Depths of the command queue and of the result queue.
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         row_index;
		logic [63:0]        row_bits;
		logic signed [11:0] pos_a_x;
		logic signed [11:0] pos_a_y;
		logic signed [11:0] pos_b_x;
		logic signed [11:0] pos_b_y;
	} in_word_t;

	typedef struct packed {
		logic boxes_overlap;
		logic collision;
	} out_word_t;

	typedef enum logic [1:0] {
		CMD_LOAD_A,
		CMD_LOAD_B,
		CMD_DETECT
	} cmd_kind_t;

	// One classified command on its way from the front end to the scan engine.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [5:0]  row;
		logic [63:0] bits;
		logic        overlap;
		logic [6:0]  ov_w;
		logic [6:0]  ov_h;
		logic [5:0]  shift_a;
		logic [5:0]  shift_b;
		logic [6:0]  row_a;
		logic [6:0]  row_b;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} bk_state_t;

endpackage

`default_nettype wire

// ----- hdl/samc_fifo.sv -----
`default_nettype none

module samc_fifo #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/samc_front.sv -----
`default_nettype none

module samc_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire samc_pkg::in_word_t item,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [6:0]        cfg_data,
	output logic                   cmd_push,
	output samc_pkg::cmd_t         cmd,
	input  wire logic              cmd_full
);

	localparam logic [6:0] MAXW7 = 7'(MAX_WIDTH);
	localparam logic [6:0] MAXH7 = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);

	function automatic logic [6:0] clamp_size(input logic [6:0] v, input logic [6:0] hi);
		logic [6:0] r;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [6:0] width_a_q, height_a_q, width_b_q, height_b_q;
	logic [6:0] wa, ha, wb, hb;

	logic                  vld_s1;
	logic                  keep_s1;
	samc_pkg::cmd_kind_t   kind_s1;
	logic [5:0]            row_s1;
	logic [63:0]           bits_s1;
	logic signed [12:0]    ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [12:0]    ra_s1, ba_s1, rb_s1, bb_s1;

	samc_pkg::cmd_kind_t   kind_in;
	logic                  keep_in;
	logic                  accept;
	logic                  leave;

	logic signed [12:0]    x0, x1, y0, y1;
	logic signed [12:0]    dw, dh, dsa, dsb, doya, doyb;
	logic                  overlap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_a_q  <= samc_pkg::SIZE_RESET;
			height_a_q <= samc_pkg::SIZE_RESET;
			width_b_q  <= samc_pkg::SIZE_RESET;
			height_b_q <= samc_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				samc_pkg::CFG_WIDTH_A:  width_a_q  <= cfg_data;
				samc_pkg::CFG_HEIGHT_A: height_a_q <= cfg_data;
				samc_pkg::CFG_WIDTH_B:  width_b_q  <= cfg_data;
				samc_pkg::CFG_HEIGHT_B: height_b_q <= cfg_data;
			endcase
		end
	end

	assign wa = clamp_size(width_a_q, MAXW7);
	assign ha = clamp_size(height_a_q, MAXH7);
	assign wb = clamp_size(width_b_q, MAXW7);
	assign hb = clamp_size(height_b_q, MAXH7);

	// Loads beyond the store and the unused request code are dropped here.
	always_comb begin
		kind_in = samc_pkg::CMD_DETECT;
		keep_in = 1'b0;
		unique case (item.req_type)
			samc_pkg::REQ_LOAD_A: begin
				kind_in = samc_pkg::CMD_LOAD_A;
				keep_in = (32'(item.row_index) < MAX_HEIGHT);
			end
			samc_pkg::REQ_LOAD_B: begin
				kind_in = samc_pkg::CMD_LOAD_B;
				keep_in = (32'(item.row_index) < MAX_HEIGHT);
			end
			samc_pkg::REQ_DETECT: begin
				kind_in = samc_pkg::CMD_DETECT;
				keep_in = 1'b1;
			end
			default: begin
				kind_in = samc_pkg::CMD_DETECT;
				keep_in = 1'b0;
			end
		endcase
	end

	assign leave    = vld_s1 && (!keep_s1 || !cmd_full);
	assign full     = vld_s1 && !leave;
	assign accept   = push && !full;
	assign cmd_push = vld_s1 && keep_s1 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (leave) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			keep_s1 <= keep_in;
			kind_s1 <= kind_in;
			row_s1  <= item.row_index;
			bits_s1 <= item.row_bits;
			ax_s1   <= {item.pos_a_x[11], item.pos_a_x};
			ay_s1   <= {item.pos_a_y[11], item.pos_a_y};
			bx_s1   <= {item.pos_b_x[11], item.pos_b_x};
			by_s1   <= {item.pos_b_y[11], item.pos_b_y};
			ra_s1   <= {item.pos_a_x[11], item.pos_a_x} + {6'd0, wa};
			ba_s1   <= {item.pos_a_y[11], item.pos_a_y} + {6'd0, ha};
			rb_s1   <= {item.pos_b_x[11], item.pos_b_x} + {6'd0, wb};
			bb_s1   <= {item.pos_b_y[11], item.pos_b_y} + {6'd0, hb};
		end
	end

	// Overlap rectangle of the two bounding boxes.
	always_comb begin
		overlap = !((ra_s1 <= bx_s1) || (ax_s1 >= rb_s1) ||
		            (ba_s1 <= by_s1) || (ay_s1 >= bb_s1));
		x0   = (ax_s1 > bx_s1) ? ax_s1 : bx_s1;
		x1   = (ra_s1 < rb_s1) ? ra_s1 : rb_s1;
		y0   = (ay_s1 > by_s1) ? ay_s1 : by_s1;
		y1   = (ba_s1 < bb_s1) ? ba_s1 : bb_s1;
		dw   = x1 - x0;
		dh   = y1 - y0;
		dsa  = x0 - ax_s1;
		dsb  = x0 - bx_s1;
		doya = y0 - ay_s1;
		doyb = y0 - by_s1;

		cmd.kind    = kind_s1;
		cmd.row     = row_s1;
		cmd.bits    = bits_s1;
		cmd.overlap = overlap;
		cmd.ov_w    = dw[6:0];
		cmd.ov_h    = dh[6:0];
		cmd.shift_a = dsa[5:0];
		cmd.shift_b = dsb[5:0];
		cmd.row_a   = doya[6:0];
		cmd.row_b   = doyb[6:0];
	end

endmodule

`default_nettype wire

// ----- hdl/samc_back.sv -----
`default_nettype none

module samc_back #(
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire samc_pkg::cmd_t     cmd,
	input  wire logic               cmd_empty,
	output logic                    cmd_pop,
	input  wire logic               res_full,
	output logic                    res_push,
	output samc_pkg::out_word_t     res
);

	localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [63:0] mask_a_q [MAX_HEIGHT];
	logic [63:0] mask_b_q [MAX_HEIGHT];

	samc_pkg::bk_state_t state_q, state_d;

	logic [6:0]  row_a_q, row_b_q, h_q, r_q;
	logic [5:0]  sa_q, sb_q;
	logic [63:0] lim_q;
	logic        hit_q;

	logic [63:0] rd_a_s1, rd_b_s1;
	logic        rd_vld_s1;

	logic        we_a, we_b, start, rd_en;
	logic [6:0]  sum_a, sum_b;
	logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
	logic        row_hit;
	logic [63:0] lim_d;

	assign wr_addr   = AW'(cmd.row);
	assign sum_a     = row_a_q + r_q;
	assign sum_b     = row_b_q + r_q;
	assign rd_addr_a = AW'(sum_a);
	assign rd_addr_b = AW'(sum_b);
	assign rd_en     = (state_q == samc_pkg::BK_SCAN);
	assign row_hit   = |((rd_a_s1 >> sa_q) & (rd_b_s1 >> sb_q) & lim_q);
	assign lim_d     = cmd.ov_w[6] ? '1 : ((64'd1 << cmd.ov_w) - 64'd1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			samc_pkg::BK_IDLE:  if (start) state_d = samc_pkg::BK_SCAN;
			samc_pkg::BK_SCAN:  if (r_q == h_q - 7'd1) state_d = samc_pkg::BK_FLUSH;
			samc_pkg::BK_FLUSH: state_d = samc_pkg::BK_IDLE;
			default:            state_d = samc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop           = 1'b0;
		we_a              = 1'b0;
		we_b              = 1'b0;
		start             = 1'b0;
		res_push          = 1'b0;
		res.boxes_overlap = 1'b0;
		res.collision     = 1'b0;
		unique case (state_q)
			samc_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd.kind)
						samc_pkg::CMD_LOAD_A: begin
							we_a    = 1'b1;
							cmd_pop = 1'b1;
						end
						samc_pkg::CMD_LOAD_B: begin
							we_b    = 1'b1;
							cmd_pop = 1'b1;
						end
						samc_pkg::CMD_DETECT: begin
							if (!res_full) begin
								cmd_pop  = 1'b1;
								start    = cmd.overlap;
								res_push = !cmd.overlap;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			samc_pkg::BK_FLUSH: begin
				res_push          = 1'b1;
				res.boxes_overlap = 1'b1;
				res.collision     = hit_q || (rd_vld_s1 && row_hit);
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= samc_pkg::BK_IDLE;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (start) begin
				hit_q <= 1'b0;
			end else if (rd_vld_s1 && row_hit) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			row_a_q <= cmd.row_a;
			row_b_q <= cmd.row_b;
			h_q     <= cmd.ov_h;
			sa_q    <= cmd.shift_a;
			sb_q    <= cmd.shift_b;
			lim_q   <= lim_d;
			r_q     <= 7'd0;
		end else if (rd_en) begin
			r_q <= r_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mask_a_q[wr_addr] <= cmd.bits;
		end
		if (we_b) begin
			mask_b_q[wr_addr] <= cmd.bits;
		end
		if (rd_en) begin
			rd_a_s1 <= mask_a_q[rd_addr_a];
			rd_b_s1 <= mask_b_q[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sprite_alpha_mask_collision_unit.sv -----
`default_nettype none

// Pixel-exact collision test between two sprites. Each input word is a mask
// row load for sprite A or B, or a detect request with both top-left corners;
// only a detect gives a result word, carrying boxes_overlap and collision.
// Words are taken by a front end that registers them, adds the sprite sizes
// to the corners and works out the overlap rectangle; classified commands
// then wait in a two-entry queue for the scan engine, and results leave
// through a two-entry queue of their own, so either side may stall freely.
// The scan engine handles a row load, or a detect whose boxes do not
// overlap, straight from idle; for a detect whose boxes overlap over h rows
// it reads one row of each mask store per cycle through the stores' single
// registered read port, then flushes the result. Sizes are written through
// the cfg port and must only change while the block is idle. Mask rows that
// were never loaded read as unknown data.
module sprite_alpha_mask_collision_unit #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire samc_pkg::in_word_t  item,
	output logic                     empty,
	input  wire logic                pop,
	output samc_pkg::out_word_t      result,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [6:0]          cfg_data
);

	localparam int CMD_W = $bits(samc_pkg::cmd_t);
	localparam int RES_W = $bits(samc_pkg::out_word_t);

	samc_pkg::cmd_t      cmd_in, cmd_out;
	samc_pkg::out_word_t res_word;
	logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic                res_push, res_full;
	logic [CMD_W-1:0]    cmd_out_bits;
	logic [RES_W-1:0]    res_out_bits;

	samc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	// Command queue between the front end and the scan engine.
	samc_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (samc_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out_bits),
		.empty   (cmd_empty)
	);

	assign cmd_out = samc_pkg::cmd_t'(cmd_out_bits);

	samc_back #(
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_word)
	);

	// Result queue; the engine only starts a detect when it has room.
	samc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (samc_pkg::RESQ_DEPTH)
	) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_word),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out_bits),
		.empty   (empty)
	);

	assign result = samc_pkg::out_word_t'(res_out_bits);

endmodule

`default_nettype wire

// ----- hdl/samc_checker.sv -----
`default_nettype none

module samc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                empty,
	input wire logic                pop,
	input wire samc_pkg::out_word_t result
);

	// Once reset has been seen at a clock edge, no result word is offered in
	// the following cycle.
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result offered during reset");

	// A collision can only be reported inside overlapping boxes.
	a_collision_needs_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.boxes_overlap |-> !result.collision)
		else $error("collision reported without box overlap");

	// A waiting result word stays put until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result word changed or vanished");

	// After a word is taken, a collision flag never appears on a word whose
	// overlap flag is clear in the following cycle.
	a_next_word_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop |=> empty || !result.collision || result.boxes_overlap)
		else $error("inconsistent result word after pop");

endmodule

bind sprite_alpha_mask_collision_unit samc_checker u_samc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire

// ----- bench/tb_sprite_alpha_mask_collision_unit.sv -----
`timescale 1ns / 1ps

// Regression bench for the pixel-exact sprite collision unit. Words are offered
// through the push/full side and results are taken through the empty/pop side.
// Every accepted word is handed to a scoreboard that keeps its own copy of the
// size registers and of both mask stores. For each detect word it works out the
// expected result word, and results are checked in order as they are popped.
module tb_sprite_alpha_mask_collision_unit;

	// The fourth request code has no meaning and must be dropped by the block.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int MASK_ROWS     = 64;
	localparam int SIZE_LIMIT    = 64;
	localparam int MAX_GAP       = 18;
	// A detect holds the scan engine for its whole overlap scan, and a few row loads
	// may still sit in the queues once the last result has gone.
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASE_WORDS   = 50;

	// Keeps the expected state of the unit and the queue of result words that
	// are still owed.
	class collision_scoreboard;
		logic [6:0]          size_reg [4];
		logic [63:0]         mask_rows_a [MASK_ROWS];
		logic [63:0]         mask_rows_b [MASK_ROWS];
		samc_pkg::out_word_t expected_q [$];
		int                  errors;

		function new();
			size_reg = '{default: samc_pkg::SIZE_RESET};
			errors = 0;
		endfunction

		function void set_size(logic [1:0] idx, logic [6:0] value);
			size_reg[idx] = value;
		endfunction

		// Size as the unit uses it: zero counts as one, anything past the
		// store's extent counts as the full extent.
		function int eff_size(logic [1:0] idx);
			int v;
			v = size_reg[idx];
			if (v < 1)
				return 1;
			if (v > SIZE_LIMIT)
				return SIZE_LIMIT;
			return v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function samc_pkg::out_word_t predict_detect(samc_pkg::in_word_t w);
			int ax, ay, bx, by, wa, ha, wb, hb;
			int x0, x1, y0, y1, ow, oh, sa, sb, oya, oyb, r;
			logic [63:0] lim, row_a, row_b;
			samc_pkg::out_word_t res;
			ax = int'($signed(w.pos_a_x));
			ay = int'($signed(w.pos_a_y));
			bx = int'($signed(w.pos_b_x));
			by = int'($signed(w.pos_b_y));
			wa = eff_size(samc_pkg::CFG_WIDTH_A);
			ha = eff_size(samc_pkg::CFG_HEIGHT_A);
			wb = eff_size(samc_pkg::CFG_WIDTH_B);
			hb = eff_size(samc_pkg::CFG_HEIGHT_B);
			res = '0;
			if (ax + wa <= bx || ax >= bx + wb || ay + ha <= by || ay >= by + hb)
				return res;
			res.boxes_overlap = 1'b1;
			x0 = (ax > bx) ? ax : bx;
			x1 = (ax + wa < bx + wb) ? ax + wa : bx + wb;
			y0 = (ay > by) ? ay : by;
			y1 = (ay + ha < by + hb) ? ay + ha : by + hb;
			ow = x1 - x0;
			oh = y1 - y0;
			sa = x0 - ax;
			sb = x0 - bx;
			oya = y0 - ay;
			oyb = y0 - by;
			lim = (ow >= 64) ? '1 : (64'd1 << ow) - 64'd1;
			for (r = 0; r < oh; r++) begin
				row_a = mask_rows_a[oya + r] >> sa;
				row_b = mask_rows_b[oyb + r] >> sb;
				if ((row_a & row_b & lim) != '0)
					res.collision = 1'b1;
			end
			return res;
		endfunction

		function void note_word(samc_pkg::in_word_t w);
			case (w.req_type)
				samc_pkg::REQ_LOAD_A: mask_rows_a[w.row_index] = w.row_bits;
				samc_pkg::REQ_LOAD_B: mask_rows_b[w.row_index] = w.row_bits;
				samc_pkg::REQ_DETECT: expected_q.push_back(predict_detect(w));
				default: ;
			endcase
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t ns: %s", $time, what);
		endfunction

		function void check_word(samc_pkg::out_word_t got);
			samc_pkg::out_word_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("result word with nothing expected: overlap %0b collision %0b",
					got.boxes_overlap, got.collision));
				return;
			end
			want = expected_q.pop_front();
			if (got.boxes_overlap !== want.boxes_overlap)
				flag($sformatf("boxes_overlap: expected %0b, got %0b",
					want.boxes_overlap, got.boxes_overlap));
			if (got.collision !== want.collision)
				flag($sformatf("collision: expected %0b, got %0b",
					want.collision, got.collision));
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                push      = 1'b0;
	logic                pop       = 1'b0;
	logic                full;
	logic                empty;
	samc_pkg::in_word_t  item      = '0;
	samc_pkg::out_word_t result;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_index = samc_pkg::CFG_WIDTH_A;
	logic [6:0] cfg_data  = '0;

	collision_scoreboard board;

	// Burst flags switch the random pacing off for a while on either side, so
	// that back-to-back traffic is seen as well as sparse traffic.
	bit tx_burst      = 1'b0;
	bit rx_burst      = 1'b0;
	// The stimulus asks for a long receiver hold-off by setting hold_request;
	// the hold-off process then keeps hold_rx high for that many cycles.
	int hold_request  = 0;
	bit hold_rx       = 1'b0;
	int cycles        = 0;

	sprite_alpha_mask_collision_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Mask rows of varied density. Dense random rows collide almost whenever
	// the boxes overlap, so sparse, single-pixel and empty rows are mixed in
	// to give clean misses as well.
	function automatic logic [63:0] mask_pattern();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3, 4: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Every field carries random content, whether or not the request uses it.
	function automatic samc_pkg::in_word_t random_word(logic [1:0] kind);
		samc_pkg::in_word_t w;
		w.req_type  = kind;
		w.row_index = 6'($urandom);
		w.row_bits  = {$urandom, $urandom};
		w.pos_a_x   = 12'($urandom);
		w.pos_a_y   = 12'($urandom);
		w.pos_b_x   = 12'($urandom);
		w.pos_b_y   = 12'($urandom);
		return w;
	endfunction

	function automatic samc_pkg::in_word_t load_word(logic [1:0] kind, logic [5:0] row,
			logic [63:0] bits);
		samc_pkg::in_word_t w;
		w = random_word(kind);
		w.row_index = row;
		w.row_bits  = bits;
		return w;
	endfunction

	// Corners are given as plain integers and wrap into the 12-bit fields.
	function automatic samc_pkg::in_word_t detect_word(int ax, int ay, int bx, int by);
		samc_pkg::in_word_t w;
		w = random_word(samc_pkg::REQ_DETECT);
		w.pos_a_x = 12'(ax);
		w.pos_a_y = 12'(ay);
		w.pos_b_x = 12'(bx);
		w.pos_b_y = 12'(by);
		return w;
	endfunction

	// Offers one word and returns at the edge where it is taken. push is left
	// high so that a following word with no gap keeps it high without a
	// glitch; it is only lowered when a gap is actually drawn.
	task automatic send_word(input samc_pkg::in_word_t w);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		board.note_word(w);
	endtask

	// Stops offering and waits until every owed result word has been popped,
	// then lets the unit run long enough to finish any trailing row loads.
	task automatic drain_block();
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [1:0] idx, input logic [6:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		board.set_size(idx, value);
	endtask

	// Sizes may only change while the unit is idle, so the queues are emptied
	// first.
	task automatic configure_sizes(input logic [6:0] wa, input logic [6:0] ha,
			input logic [6:0] wb, input logic [6:0] hb);
		drain_block();
		write_size(samc_pkg::CFG_WIDTH_A, wa);
		write_size(samc_pkg::CFG_HEIGHT_A, ha);
		write_size(samc_pkg::CFG_WIDTH_B, wb);
		write_size(samc_pkg::CFG_HEIGHT_B, hb);
		cfg_we <= 1'b0;
	endtask

	// Random traffic under the current sizes. Most detects place sprite B in
	// a band around sprite A, so that touching edges, thin slivers and full
	// overlaps all turn up; some sit against the ends of the coordinate range
	// and a few are placed anywhere. Unused requests do not count.
	task automatic random_phase(input int count);
		int sent, pick, wa, ha, wb, hb, ax, ay, bx, by;
		sent = 0;
		wa = board.eff_size(samc_pkg::CFG_WIDTH_A);
		ha = board.eff_size(samc_pkg::CFG_HEIGHT_A);
		wb = board.eff_size(samc_pkg::CFG_WIDTH_B);
		hb = board.eff_size(samc_pkg::CFG_HEIGHT_B);
		while (sent < count) begin
			pick = $urandom_range(0, 19);
			if (pick < 7) begin
				send_word(load_word(samc_pkg::REQ_LOAD_A, 6'($urandom), mask_pattern()));
				sent++;
			end else if (pick < 14) begin
				send_word(load_word(samc_pkg::REQ_LOAD_B, 6'($urandom), mask_pattern()));
				sent++;
			end else if (pick == 19) begin
				send_word(random_word(REQ_UNUSED));
			end else begin
				pick = $urandom_range(0, 7);
				if (pick == 0) begin
					send_word(random_word(samc_pkg::REQ_DETECT));
				end else begin
					if (pick == 1) begin
						ax = $urandom_range(0, 1) ? 2047 - int'($urandom_range(0, 70))
							: int'($urandom_range(0, 70)) - 2048;
						ay = $urandom_range(0, 1) ? 2047 - int'($urandom_range(0, 70))
							: int'($urandom_range(0, 70)) - 2048;
					end else begin
						ax = int'($urandom_range(0, 4095)) - 2048;
						ay = int'($urandom_range(0, 4095)) - 2048;
					end
					bx = ax - wb - 3 + int'($urandom_range(0, wa + wb + 6));
					by = ay - hb - 3 + int'($urandom_range(0, ha + hb + 6));
					send_word(detect_word(ax, ay, bx, by));
				end
				sent++;
			end
		end
	endtask

	// Result side: pops with random stalls and defers to the hold-off flag.
	// As on the sending side, pop is only lowered when a stall is drawn.
	initial begin : result_drain
		int gap;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0 || hold_rx) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rx)
					@(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			board.check_word(result);
		end
	end

	// Long receiver hold-off, timed here in its own process so that the
	// sender keeps offering words and the unit is driven into back-pressure.
	initial begin : hold_off
		forever begin
			wait (hold_request > 0);
			hold_rx = 1'b1;
			repeat (hold_request) @(posedge clk);
			hold_rx = 1'b0;
			hold_request = 0;
		end
	end

	// Guard against a hung unit. The limit is several times the slowest
	// legal run: every word at the longest gap, every detect at the longest
	// scan and every result at the longest stall, plus hold-offs and drains.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("sprite_alpha_mask_collision_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		int r;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// The mask stores hold rubbish until written, so every row of both
		// stores is loaded before any detect can read it.
		for (r = 0; r < MASK_ROWS; r++) begin
			send_word(load_word(samc_pkg::REQ_LOAD_A, 6'(r), mask_pattern()));
			send_word(load_word(samc_pkg::REQ_LOAD_B, 6'(r), mask_pattern()));
		end

		// Directed cases at the reset sizes of 64 by 64: identical corners,
		// edges that just touch against edges that overlap by one pixel, the
		// ends of the coordinate range where the far edges pass beyond the
		// 12-bit field, and a dropped unused request.
		send_word(detect_word(0, 0, 0, 0));
		send_word(detect_word(0, 0, 64, 0));
		send_word(detect_word(0, 0, 63, 0));
		send_word(detect_word(0, 0, 0, 64));
		send_word(detect_word(0, 0, 0, 63));
		send_word(detect_word(0, 0, -64, -64));
		send_word(detect_word(0, 0, -63, -63));
		send_word(detect_word(-2048, -2048, 2047, 2047));
		send_word(detect_word(2047, 2047, 2047, 2047));
		send_word(detect_word(-2048, -2048, -2048, -2048));
		send_word(detect_word(2047, -2048, 2000, -2048));
		send_word(detect_word(-2048, 2047, -2010, 2047));
		send_word(random_word(REQ_UNUSED));
		// A single-pixel overlap, first with both pixels covered, then with
		// the covered bit of A moved out of the overlap to the top of its row.
		send_word(load_word(samc_pkg::REQ_LOAD_A, 6'd0, '1));
		send_word(load_word(samc_pkg::REQ_LOAD_B, 6'd63, '1));
		send_word(detect_word(0, 0, -63, -63));
		send_word(load_word(samc_pkg::REQ_LOAD_A, 6'd0, 64'h8000_0000_0000_0000));
		send_word(detect_word(0, 0, -63, -63));
		send_word(detect_word(-63, -63, 0, 0));
		send_word(load_word(samc_pkg::REQ_LOAD_B, 6'd0, '0));
		send_word(detect_word(5, 0, 0, 0));

		hold_request = HOLD_CYCLES;
		random_phase(PHASE_WORDS);

		// One-pixel sprites, then the clamping of zero and oversized values.
		configure_sizes(7'd1, 7'd1, 7'd1, 7'd1);
		random_phase(PHASE_WORDS);
		configure_sizes(7'd0, 7'd0, 7'd127, 7'd127);
		random_phase(PHASE_WORDS);
		configure_sizes(7'd127, 7'd64, 7'd1, 7'd0);
		random_phase(PHASE_WORDS);

		// Full-size sprites give the longest scans, which suits a second
		// hold-off.
		configure_sizes(7'd64, 7'd64, 7'd64, 7'd64);
		hold_request = HOLD_CYCLES;
		random_phase(PHASE_WORDS);

		configure_sizes(7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)),
			7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)));
		random_phase(PHASE_WORDS);
		configure_sizes(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
		random_phase(PHASE_WORDS);

		drain_block();
		if (board.errors == 0 && board.pending() == 0)
			$display("sprite_alpha_mask_collision_unit regression: pass");
		else
			$display("sprite_alpha_mask_collision_unit regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/samc_pkg.sv
hdl/samc_fifo.sv
hdl/samc_front.sv
hdl/samc_back.sv
hdl/sprite_alpha_mask_collision_unit.sv
hdl/samc_checker.sv
bench/tb_sprite_alpha_mask_collision_unit.sv
